// ===== src/smac_pkg.sv =====
// ----------------------------------------------------------------------------
// smac_pkg
// Shared types and constants for the stereo mix accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package smac_pkg;

    localparam int SLOT_W     = 11;
    localparam int SAMPLE_W   = 16;
    localparam int VOL_W      = 8;
    localparam int GAIN_W     = 9;
    localparam int RSL_W      = 5;
    localparam int OUT_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam int DEF_BUFFER_DEPTH = 2048;
    localparam int DEF_ACC_WIDTH    = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MASTER_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_SIXTEEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_STEREO  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_LOG2   = 2'd3;

    localparam logic OP_MIX  = 1'b0;
    localparam logic OP_EMIT = 1'b1;

    localparam logic [GAIN_W-1:0] RST_MASTER_GAIN = 9'd179;
    localparam logic [RSL_W-1:0]  RST_RING_LOG2   = 5'd14;
    localparam logic [RSL_W-1:0]  RING_LOG2_MAX   = 5'd16;

    localparam logic [VOL_W-1:0] VOL8_MASK = 8'hF8;
    localparam int               MIX_SHIFT = 8;
    localparam int               OUT_MAX   = 32'sh0000_7fff;
    localparam int               OUT_MIN   = -32'sh0000_8000;

    typedef struct packed {
        logic                       opcode;
        logic [SLOT_W-1:0]          slot;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       is_eight_bit;
        logic [VOL_W-1:0]           left_vol;
        logic [VOL_W-1:0]           right_vol;
    } t_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] left_out;
        logic signed [OUT_W-1:0] right_out;
        logic [OUT_W-1:0]        ring_index;
    } t_result;

    typedef struct packed {
        logic [GAIN_W-1:0] master_gain;
        logic              out_sixteen_bit;
        logic              out_stereo;
        logic [RSL_W-1:0]  ring_size_log2;
    } t_cfg;

endpackage

`default_nettype wire

// ===== src/stereo_mix_accumulate_clamp_top.sv =====
// ----------------------------------------------------------------------------
// stereo_mix_accumulate_clamp_top
// Stereo paint buffer: mix beats add scaled samples into a slot, emit beats
// read the slot out saturated, clear it and tag it with a ring index.
// Throughput is one beat per clock while busy is low. o_valid follows an emit
// beat through the stage-1, stage-2 and result registers and stays high for
// one cycle. The receiver cannot stall it. The left and right accumulators
// share one RAM row, read-modify-written through a three-stage pipeline with
// forwarding of the two newest writes. After reset, busy stays high while the
// RAM is cleared, one row a cycle. Configuration writes are taken during that
// time.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_mix_accumulate_clamp_top
    import smac_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH,
    parameter int ACC_WIDTH    = DEF_ACC_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire t_item                 i_item,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output logic                       o_valid,
    output t_result                    o_result
);

    localparam int AW    = $clog2(BUFFER_DEPTH);
    localparam int ROW_W = 2 * ACC_WIDTH;

    t_cfg                 r_cfg;
    logic                 r_clr;
    logic [AW-1:0]        r_clr_addr;
    logic                 n_accept;
    logic [SLOT_W+AW-1:0] n_slot_ext;
    logic [AW-1:0]        n_addr;

    logic                 r_s1_vld;
    logic                 r_s1_op;
    logic [AW-1:0]        r_s1_addr;
    logic                 r_s2_vld;
    logic                 r_s2_op;
    logic [AW-1:0]        r_s2_addr;
    logic [ROW_W-1:0]     r_s2_acc;
    logic                 r_s3_vld;
    logic [AW-1:0]        r_s3_addr;
    logic [ROW_W-1:0]     r_s3_data;

    logic [ROW_W-1:0]     w_rdata;
    logic [ACC_WIDTH-1:0] w_term_l;
    logic [ACC_WIDTH-1:0] w_term_r;
    logic [ROW_W-1:0]     n_s2_wdata;
    logic [ROW_W-1:0]     n_fwd;
    logic                 n_we;
    logic [AW-1:0]        n_waddr;
    logic [ROW_W-1:0]     n_wdata;

    assign busy       = r_clr;
    assign n_accept   = start && !r_clr;
    assign n_slot_ext = {{AW{1'b0}}, i_item.slot};
    assign n_addr     = n_slot_ext[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.master_gain     <= RST_MASTER_GAIN;
            r_cfg.out_sixteen_bit <= 1'b1;
            r_cfg.out_stereo      <= 1'b1;
            r_cfg.ring_size_log2  <= RST_RING_LOG2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MASTER_GAIN: r_cfg.master_gain     <= i_cfg_wdata[GAIN_W-1:0];
                CFG_OUT_SIXTEEN: r_cfg.out_sixteen_bit <= i_cfg_wdata[0];
                CFG_OUT_STEREO:  r_cfg.out_stereo      <= i_cfg_wdata[0];
                CFG_RING_LOG2:   r_cfg.ring_size_log2  <= i_cfg_wdata[RSL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(BUFFER_DEPTH - 1)) begin
                r_clr <= 1'b0;
            end
        end
    end

    smac_ram #(
        .WIDTH (ROW_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (n_waddr),
        .i_wdata (n_wdata),
        .i_raddr (n_addr),
        .o_rdata (w_rdata)
    );

    smac_term #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_term (
        .i_clk    (i_clk),
        .i_item   (i_item),
        .i_gain   (r_cfg.master_gain),
        .o_term_l (w_term_l),
        .o_term_r (w_term_r)
    );

    always_comb begin
        if (r_s2_op == OP_EMIT) begin
            n_s2_wdata = '0;
        end else begin
            n_s2_wdata = {r_s2_acc[ROW_W-1:ACC_WIDTH] + w_term_l,
                          r_s2_acc[ACC_WIDTH-1:0] + w_term_r};
        end

        if (r_s2_vld && (r_s2_addr == r_s1_addr)) begin
            n_fwd = n_s2_wdata;
        end else if (r_s3_vld && (r_s3_addr == r_s1_addr)) begin
            n_fwd = r_s3_data;
        end else begin
            n_fwd = w_rdata;
        end

        if (r_clr) begin
            n_we    = 1'b1;
            n_waddr = r_clr_addr;
            n_wdata = '0;
        end else begin
            n_we    = r_s2_vld;
            n_waddr = r_s2_addr;
            n_wdata = n_s2_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= n_accept;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_op   <= i_item.opcode;
        r_s1_addr <= n_addr;
        r_s2_op   <= r_s1_op;
        r_s2_addr <= r_s1_addr;
        r_s2_acc  <= n_fwd;
        r_s3_addr <= r_s2_addr;
        r_s3_data <= n_s2_wdata;
    end

    smac_emit #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (r_s2_vld && (r_s2_op == OP_EMIT)),
        .i_acc_l  (r_s2_acc[ROW_W-1:ACC_WIDTH]),
        .i_acc_r  (r_s2_acc[ACC_WIDTH-1:0]),
        .i_cfg    (r_cfg),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

// ===== src/smac_ram.sv =====
// ----------------------------------------------------------------------------
// smac_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module smac_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== src/smac_term.sv =====
// ----------------------------------------------------------------------------
// smac_term
// Two-stage mix term pipeline: sample times volume, then times master gain.
// ----------------------------------------------------------------------------
`default_nettype none

module smac_term
    import smac_pkg::*;
#(
    parameter int ACC_WIDTH = DEF_ACC_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire t_item                 i_item,
    input  wire logic [GAIN_W-1:0]     i_gain,
    output logic [ACC_WIDTH-1:0]       o_term_l,
    output logic [ACC_WIDTH-1:0]       o_term_r
);

    localparam int PV_W = SAMPLE_W + VOL_W;
    localparam int PG_W = PV_W + GAIN_W;
    localparam int EXT_W = PG_W + ACC_WIDTH;

    logic signed [SAMPLE_W-1:0] n_s;
    logic [VOL_W-1:0]           n_vl;
    logic [VOL_W-1:0]           n_vr;
    logic signed [PV_W-1:0]     r_pl;
    logic signed [PV_W-1:0]     r_pr;
    logic                       r_eight;
    logic signed [PG_W-1:0]     n_gl;
    logic signed [PG_W-1:0]     n_gr;
    logic signed [PG_W-1:0]     n_hl;
    logic signed [PG_W-1:0]     n_hr;
    logic signed [EXT_W-1:0]    n_el;
    logic signed [EXT_W-1:0]    n_er;

    always_comb begin
        if (i_item.is_eight_bit) begin
            n_s  = SAMPLE_W'($signed(i_item.sample[7:0]));
            n_vl = i_item.left_vol & VOL8_MASK;
            n_vr = i_item.right_vol & VOL8_MASK;
        end else begin
            n_s  = i_item.sample;
            n_vl = i_item.left_vol;
            n_vr = i_item.right_vol;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pl    <= n_s * $signed({1'b0, n_vl});
        r_pr    <= n_s * $signed({1'b0, n_vr});
        r_eight <= i_item.is_eight_bit;
    end

    always_comb begin
        n_gl = r_pl * $signed({1'b0, i_gain});
        n_gr = r_pr * $signed({1'b0, i_gain});
        n_hl = r_eight ? n_gl : (n_gl >>> MIX_SHIFT);
        n_hr = r_eight ? n_gr : (n_gr >>> MIX_SHIFT);
        n_el = EXT_W'(n_hl);
        n_er = EXT_W'(n_hr);
    end

    always_ff @(posedge i_clk) begin
        o_term_l <= n_el[ACC_WIDTH-1:0];
        o_term_r <= n_er[ACC_WIDTH-1:0];
    end

endmodule

`default_nettype wire

// ===== src/smac_emit.sv =====
// ----------------------------------------------------------------------------
// smac_emit
// Output formatter: shift, saturate, format, ring index and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module smac_emit
    import smac_pkg::*;
#(
    parameter int ACC_WIDTH = DEF_ACC_WIDTH
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_fire,
    input  wire logic [ACC_WIDTH-1:0] i_acc_l,
    input  wire logic [ACC_WIDTH-1:0] i_acc_r,
    input  wire t_cfg                 i_cfg,
    output logic                      o_valid,
    output t_result                   o_result
);

    localparam int V_W = ACC_WIDTH - MIX_SHIFT;

    logic [OUT_W-1:0] r_frame;
    logic [RSL_W-1:0] n_lg;
    logic [OUT_W:0]   n_mask;
    logic [OUT_W-1:0] n_pos;
    t_result          n_result;

    function automatic logic [OUT_W-1:0] fmt(input logic [ACC_WIDTH-1:0] acc,
                                             input logic sixteen);
        logic signed [V_W-1:0] v;
        int                    vi;
        logic [OUT_W-1:0]      s;
        v  = $signed(acc[ACC_WIDTH-1:MIX_SHIFT]);
        vi = int'(v);
        if (vi > OUT_MAX) begin
            s = OUT_W'(OUT_MAX);
        end else if (vi < OUT_MIN) begin
            s = OUT_W'(OUT_MIN);
        end else begin
            s = OUT_W'(vi);
        end
        if (sixteen) begin
            return s;
        end
        return {8'h00, ~s[15], s[14:8]};
    endfunction

    always_comb begin
        n_lg   = (i_cfg.ring_size_log2 > RING_LOG2_MAX) ? RING_LOG2_MAX
                                                        : i_cfg.ring_size_log2;
        n_mask = ((OUT_W+1)'(1) << n_lg) - (OUT_W+1)'(1);
        n_pos  = i_cfg.out_stereo ? {r_frame[OUT_W-2:0], 1'b0} : r_frame;
        n_result.left_out   = fmt(i_acc_l, i_cfg.out_sixteen_bit);
        n_result.right_out  = i_cfg.out_stereo ? fmt(i_acc_r, i_cfg.out_sixteen_bit)
                                               : '0;
        n_result.ring_index = n_pos & n_mask[OUT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            r_frame <= '0;
        end else begin
            o_valid <= i_fire;
            if (i_fire) begin
                r_frame <= r_frame + OUT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            o_result <= n_result;
        end
    end

endmodule

`default_nettype wire
